// ----- design/krt_pkg.sv -----
package krt_pkg;

  // Table geometry and field widths
  localparam int DEF_TABLE_DEPTH = 16;
  localparam int REQ_W           = 2;
  localparam int KEY_W           = 27;
  localparam int AGE_W           = 7;
  localparam int STATUS_W        = 2;
  localparam int SLOT_W          = 4;
  localparam int TOTAL_W         = 5;

  // Age bucket bounds: young below YOUNG_LIMIT, old from OLD_START up
  localparam int YOUNG_LIMIT = 19;
  localparam int OLD_START   = 36;
  localparam int TOTAL_MAX   = 31;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_DUPLICATE = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    BKT_YOUNG,
    BKT_MIDDLE,
    BKT_OLD
  } bucket_t;

  // One stored entry: key in the low bits, age above it
  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic [KEY_W-1:0] key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Sort an age into its bucket
  function automatic bucket_t age_bucket(input logic [AGE_W-1:0] age);
    bucket_t b;
    if (age < AGE_W'(YOUNG_LIMIT)) begin
      b = BKT_YOUNG;
    end else if (age < AGE_W'(OLD_START)) begin
      b = BKT_MIDDLE;
    end else begin
      b = BKT_OLD;
    end
    return b;
  endfunction

  // Clamp a bucket count to the output field
  function automatic logic [TOTAL_W-1:0] sat_total(input logic [31:0] v);
    logic [TOTAL_W-1:0] r;
    if (v > 32'(TOTAL_MAX)) begin
      r = TOTAL_W'(TOTAL_MAX);
    end else begin
      r = v[TOTAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/keyed_record_table.sv -----
// Keyed record table: TABLE_DEPTH slots, each a valid mark, a 27-bit key and a 7-bit age.
// Keys and ages sit in a memory with one write port and a registered read port; valid
// marks and the three age-bucket counts are flip-flops, so reset and a clear request empty
// the table at once with no clearing pass. Insert, delete and lookup read every slot in turn,
// one per cycle, tracking the lowest free slot and the lowest valid match, then commit the
// result and the table update once the output register is free; a clear skips the scan.
// One item is worked on at a time; the next is taken while the previous result still waits
// in the output register. Bucket totals saturate at 31.
module keyed_record_table #(
  parameter int TABLE_DEPTH = krt_pkg::DEF_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // request item
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [26:0] record_key, [33:27] record_age, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  // result item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [3:0] slot_index, [10:4] stored_age, [15:11] young_total,
                                 // [20:16] middle_total, [25:21] old_total, rest zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDXW:0] SCAN_END = (IDXW + 1)'(TABLE_DEPTH);

  localparam int KW = krt_pkg::KEY_W;
  localparam int AW = krt_pkg::AGE_W;
  localparam int TW = krt_pkg::TOTAL_W;

  krt_pkg::state_t state, state_next;

  // request held for the scan
  krt_pkg::req_t   req;
  logic [KW-1:0]   key;
  logic [AW-1:0]   age;

  // scan progress and results
  logic [IDXW:0]   scan_addr;
  logic            pend;
  logic [IDXW-1:0] pend_idx;
  logic            found;
  logic [IDXW-1:0] match_idx;
  logic [AW-1:0]   match_age;
  logic            free_found;
  logic [IDXW-1:0] free_idx;

  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [CW-1:0]   young_count, middle_count, old_count;
  logic [CW-1:0]   young_next, middle_next, old_next;

  // output register
  krt_pkg::status_t out_status;
  logic [TW-1:0]   out_slot_ext;
  logic [krt_pkg::SLOT_W-1:0] out_slot;
  logic [AW-1:0]   out_age;
  logic [TW-1:0]   out_young, out_middle, out_old;

  // control
  logic            accept;
  logic            rd_en;
  logic            finish_go;
  krt_pkg::entry_t rd_data;
  krt_pkg::entry_t wr_data;
  logic            wr_en;
  logic [IDXW-1:0] wr_addr;

  // commit decisions
  krt_pkg::status_t fin_status;
  logic [IDXW-1:0] fin_slot;
  logic [AW-1:0]   fin_age;
  logic            set_valid, clr_valid, clr_all;
  logic            inc_en, dec_en;
  krt_pkg::bucket_t inc_bkt, dec_bkt;
  logic [31:0]     fin_slot_wide;

  assign out_slot_ext = TW'(out_slot);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      krt_pkg::ST_IDLE: begin
        if (accept) begin
          if (krt_pkg::req_t'(s_tuser) == krt_pkg::REQ_CLEAR) begin
            state_next = krt_pkg::ST_FINISH;
          end else begin
            state_next = krt_pkg::ST_SCAN;
          end
        end
      end
      krt_pkg::ST_SCAN: begin
        if (scan_addr == SCAN_END) begin
          state_next = krt_pkg::ST_FINISH;
        end
      end
      krt_pkg::ST_FINISH: begin
        if (finish_go) begin
          state_next = krt_pkg::ST_IDLE;
        end
      end
      default: state_next = krt_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_tready  = (state == krt_pkg::ST_IDLE);
    rd_en     = (state == krt_pkg::ST_SCAN) && (scan_addr < SCAN_END);
    finish_go = (state == krt_pkg::ST_FINISH) && (!m_tvalid || m_tready);
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= krt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= krt_pkg::req_t'(s_tuser);
      key <= s_tdata[KW-1:0];
      age <= s_tdata[KW+AW-1:KW];
    end
  end

  // Advance the scan address and track the lowest free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr  <= '0;
      pend       <= 1'b0;
      free_found <= 1'b0;
    end else begin
      pend <= rd_en;
      if (accept) begin
        scan_addr  <= '0;
        free_found <= 1'b0;
      end else if (rd_en) begin
        scan_addr <= scan_addr + (IDXW + 1)'(1);
        if (!free_found && !slot_valid[scan_addr[IDXW-1:0]]) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_idx <= scan_addr[IDXW-1:0];
      if (!free_found && !slot_valid[scan_addr[IDXW-1:0]]) begin
        free_idx <= scan_addr[IDXW-1:0];
      end
    end
  end

  // Compare returned entries, keep the lowest valid match
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept) begin
      found <= 1'b0;
    end else if (pend && !found && slot_valid[pend_idx] && rd_data.key == key) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pend && !found && slot_valid[pend_idx] && rd_data.key == key) begin
      match_idx <= pend_idx;
      match_age <= rd_data.age;
    end
  end

  // Decide the result and the table update
  always_comb begin
    fin_status = krt_pkg::STS_OK;
    fin_slot   = '0;
    fin_age    = '0;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    clr_all    = 1'b0;
    inc_en     = 1'b0;
    dec_en     = 1'b0;
    inc_bkt    = krt_pkg::age_bucket(age);
    dec_bkt    = krt_pkg::age_bucket(match_age);
    case (req)
      krt_pkg::REQ_INSERT: begin
        if (!free_found) begin
          fin_status = krt_pkg::STS_FULL;
        end else if (found) begin
          fin_status = krt_pkg::STS_DUPLICATE;
          fin_slot   = match_idx;
          fin_age    = match_age;
        end else begin
          fin_slot  = free_idx;
          set_valid = 1'b1;
          inc_en    = 1'b1;
        end
      end
      krt_pkg::REQ_DELETE, krt_pkg::REQ_LOOKUP: begin
        if (!found) begin
          fin_status = krt_pkg::STS_NOT_FOUND;
        end else begin
          fin_slot = match_idx;
          fin_age  = match_age;
          if (req == krt_pkg::REQ_DELETE) begin
            clr_valid = 1'b1;
            dec_en    = 1'b1;
          end
        end
      end
      default: clr_all = 1'b1;
    endcase
    fin_slot_wide = 32'(fin_slot);
  end

  // Bucket counts after this request
  always_comb begin
    young_next  = young_count;
    middle_next = middle_count;
    old_next    = old_count;
    if (clr_all) begin
      young_next  = '0;
      middle_next = '0;
      old_next    = '0;
    end
    if (inc_en) begin
      case (inc_bkt)
        krt_pkg::BKT_YOUNG:  young_next  = young_count + CW'(1);
        krt_pkg::BKT_MIDDLE: middle_next = middle_count + CW'(1);
        default:             old_next    = old_count + CW'(1);
      endcase
    end
    if (dec_en) begin
      case (dec_bkt)
        krt_pkg::BKT_YOUNG:  young_next  = young_count - CW'(1);
        krt_pkg::BKT_MIDDLE: middle_next = middle_count - CW'(1);
        default:             old_next    = old_count - CW'(1);
      endcase
    end
  end

  // Commit valid marks and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      young_count  <= '0;
      middle_count <= '0;
      old_count    <= '0;
    end else if (finish_go) begin
      young_count  <= young_next;
      middle_count <= middle_next;
      old_count    <= old_next;
      if (clr_all) begin
        slot_valid <= '0;
      end else if (set_valid) begin
        slot_valid[free_idx] <= 1'b1;
      end else if (clr_valid) begin
        slot_valid[match_idx] <= 1'b0;
      end
    end
  end

  // Write the new entry on a successful insert
  assign wr_en        = finish_go && set_valid;
  assign wr_addr      = free_idx;
  assign wr_data.key  = key;
  assign wr_data.age  = age;

  krt_slot_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_addr[IDXW-1:0]),
    .rd_data (rd_data)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_status <= fin_status;
      out_slot   <= fin_slot_wide[krt_pkg::SLOT_W-1:0];
      out_age    <= fin_age;
      out_young  <= krt_pkg::sat_total(32'(young_next));
      out_middle <= krt_pkg::sat_total(32'(middle_next));
      out_old    <= krt_pkg::sat_total(32'(old_next));
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {6'd0, out_old, out_middle, out_young, out_age, out_slot_ext[3:0]};

endmodule

// ----- design/krt_slot_mem.sv -----
module krt_slot_mem #(
  parameter int TABLE_DEPTH = krt_pkg::DEF_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] wr_addr,
  input  krt_pkg::entry_t                   wr_data,
  input  logic                              rd_en,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
  output krt_pkg::entry_t                   rd_data
);

  krt_pkg::entry_t mem [TABLE_DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
